// ===== rtl/tmvs_pkg.sv =====
`timescale 1ns / 1ps

package tmvs_pkg;

    localparam int MAP_MAX_COLS  = 64;
    localparam int MAP_MAX_ROWS  = 64;
    localparam int VIEW_MAX      = 8;
    localparam int MATERIAL_BITS = 10;

    localparam int STORE_DEPTH = MAP_MAX_COLS * MAP_MAX_ROWS;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int COORD_BITS  = 6;
    localparam int DIM_BITS    = 7;
    localparam int SIZE_BITS   = 10;
    localparam int COUNT_BITS  = 11;
    localparam int PIX_BITS    = 16;
    localparam int NUM_BITS    = 17;
    localparam int DEN_BITS    = SIZE_BITS + 1;
    localparam int SUM_BITS    = 19;
    localparam int ORG_BITS    = 19;
    localparam int CFG_IDX_BITS = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_VIEW  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TILE_SIZE      = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MATERIAL_COUNT = 2'd3;

    localparam logic [1:0] DIV_X_LO = 2'd0;
    localparam logic [1:0] DIV_X_HI = 2'd1;
    localparam logic [1:0] DIV_Y_LO = 2'd2;
    localparam logic [1:0] DIV_Y_HI = 2'd3;

    typedef struct packed {
        logic       clear_en;
        logic       wr_tile;
        logic       load_view;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_capture;
        logic       win_load;
        logic       scan_step;
        logic       emit_empty;
    } tmvs_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_done;
        logic win_empty;
        logic scan_end;
    } tmvs_stat_t;

endpackage

// ===== rtl/tile_map_view_scanner.sv =====
`timescale 1ns / 1ps
// A tile write leaves the controller idle, so busy stays low; a view scan runs four 17-step
// divisions on one shared divider and then emits up to 64 tiles, one per cycle.
// An empty view gives a single result with tile_valid low and last set.
// busy stays high through a view scan, so the next transfer waits until the scan ends.
// Reset starts a pass that clears every entry of the tile store; busy stays high until it ends.
// Results are strobed for one cycle and cannot be stalled.
module tile_map_view_scanner (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   cmd,
    input  logic [tmvs_pkg::COORD_BITS-1:0]        tile_col,
    input  logic [tmvs_pkg::COORD_BITS-1:0]        tile_row,
    input  logic [tmvs_pkg::MATERIAL_BITS-1:0]     material_in,
    input  logic signed [tmvs_pkg::PIX_BITS-1:0]   center_x,
    input  logic signed [tmvs_pkg::PIX_BITS-1:0]   center_y,
    input  logic [tmvs_pkg::PIX_BITS-1:0]          view_width,
    input  logic [tmvs_pkg::PIX_BITS-1:0]          view_height,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tmvs_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [tmvs_pkg::COUNT_BITS-1:0]        cfg_data,
    output logic                                   out_valid,
    output logic                                   tile_valid,
    output logic [tmvs_pkg::COORD_BITS-1:0]        out_col,
    output logic [tmvs_pkg::COORD_BITS-1:0]        out_row,
    output logic [tmvs_pkg::MATERIAL_BITS-1:0]     out_material,
    output logic signed [tmvs_pkg::ORG_BITS-1:0]   origin_x_q,
    output logic signed [tmvs_pkg::ORG_BITS-1:0]   origin_y_q,
    output logic                                   last
);
    import tmvs_pkg::*;

    tmvs_cmd_t  ctl;
    tmvs_stat_t stat;

    assign cfg_ready = 1'b1;

    tmvs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .ctl   (ctl),
        .stat  (stat)
    );

    tmvs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tile_col     (tile_col),
        .tile_row     (tile_row),
        .material_in  (material_in),
        .center_x     (center_x),
        .center_y     (center_y),
        .view_width   (view_width),
        .view_height  (view_height),
        .out_valid    (out_valid),
        .tile_valid   (tile_valid),
        .out_col      (out_col),
        .out_row      (out_row),
        .out_material (out_material),
        .origin_x_q   (origin_x_q),
        .origin_y_q   (origin_y_q),
        .last         (last)
    );

endmodule

// ===== rtl/tmvs_div.sv =====
`timescale 1ns / 1ps

module tmvs_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tmvs_pkg::NUM_BITS-1:0]     num,
    input  logic [tmvs_pkg::DEN_BITS-1:0]     den,
    output logic                              done,
    output logic [tmvs_pkg::NUM_BITS-1:0]     quot,
    output logic                              rem_nz
);
    import tmvs_pkg::*;

    localparam int CNT_W = $clog2(NUM_BITS);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_BITS-1]};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = num;
            rem_next = '0;
            den_next = den;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_BITS'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(NUM_BITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done   = done_reg;
    assign quot   = quo_reg;
    assign rem_nz = |rem_reg;

endmodule

// ===== rtl/tmvs_dp.sv =====
`timescale 1ns / 1ps

module tmvs_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tmvs_pkg::tmvs_cmd_t                    ctl,
    output tmvs_pkg::tmvs_stat_t                   stat,
    input  logic                                   cfg_we,
    input  logic [tmvs_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [tmvs_pkg::COUNT_BITS-1:0]        cfg_data,
    input  logic [tmvs_pkg::COORD_BITS-1:0]        tile_col,
    input  logic [tmvs_pkg::COORD_BITS-1:0]        tile_row,
    input  logic [tmvs_pkg::MATERIAL_BITS-1:0]     material_in,
    input  logic signed [tmvs_pkg::PIX_BITS-1:0]   center_x,
    input  logic signed [tmvs_pkg::PIX_BITS-1:0]   center_y,
    input  logic [tmvs_pkg::PIX_BITS-1:0]          view_width,
    input  logic [tmvs_pkg::PIX_BITS-1:0]          view_height,
    output logic                                   out_valid,
    output logic                                   tile_valid,
    output logic [tmvs_pkg::COORD_BITS-1:0]        out_col,
    output logic [tmvs_pkg::COORD_BITS-1:0]        out_row,
    output logic [tmvs_pkg::MATERIAL_BITS-1:0]     out_material,
    output logic signed [tmvs_pkg::ORG_BITS-1:0]   origin_x_q,
    output logic signed [tmvs_pkg::ORG_BITS-1:0]   origin_y_q,
    output logic                                   last
);
    import tmvs_pkg::*;

    localparam int PROD_BITS = COORD_BITS + SIZE_BITS;

    logic [MATERIAL_BITS-1:0] mem [STORE_DEPTH];

    logic [DIM_BITS-1:0]   map_width_reg, map_height_reg;
    logic [SIZE_BITS-1:0]  tile_size_reg;
    logic [COUNT_BITS-1:0] material_count_reg;

    logic [ADDR_BITS-1:0]  clr_cnt_reg;

    logic signed [PIX_BITS-1:0] cx_reg, cy_reg;
    logic [PIX_BITS-1:0]        sx_reg, sy_reg;

    logic [DIM_BITS-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [DIM_BITS-1:0] x_end_reg, y_end_reg;
    logic [DIM_BITS-1:0] x_cnt_reg, x_cnt_next;
    logic [DIM_BITS-1:0] y_cnt_reg, y_cnt_next;

    logic [MATERIAL_BITS-1:0] rdata_reg;

    logic                      ov_reg, tv_reg, last_reg;
    logic [COORD_BITS-1:0]     col_reg, row_reg;
    logic signed [ORG_BITS-1:0] ox_reg, oy_reg;

    logic [DIM_BITS-1:0]  w_eff, h_eff;
    logic [SIZE_BITS-1:0] t_eff;

    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [MATERIAL_BITS-1:0] mem_wdata;
    logic [ADDR_BITS:0]   wr_addr_full;
    logic                 wr_ok;
    logic [ADDR_BITS:0]   rd_addr_full;

    logic signed [SUM_BITS-1:0] c2, s_ext, sum;
    logic [NUM_BITS-1:0]  div_num;
    logic                 div_done, div_rem_nz;
    logic [NUM_BITS-1:0]  div_quot;
    logic [NUM_BITS:0]    q_adj;
    logic [DIM_BITS-1:0]  lim, bound;

    logic [DIM_BITS-1:0]  x_cap, y_cap;
    logic                 scan_end;
    logic [PROD_BITS-1:0] px, py;
    logic [ORG_BITS-1:0]  ox_calc, oy_calc;

    assign w_eff = (map_width_reg > DIM_BITS'(MAP_MAX_COLS)) ? DIM_BITS'(MAP_MAX_COLS)
                                                             : map_width_reg;
    assign h_eff = (map_height_reg > DIM_BITS'(MAP_MAX_ROWS)) ? DIM_BITS'(MAP_MAX_ROWS)
                                                              : map_height_reg;
    assign t_eff = (tile_size_reg == '0) ? SIZE_BITS'(1) : tile_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg      <= DIM_BITS'(64);
            map_height_reg     <= DIM_BITS'(64);
            tile_size_reg      <= SIZE_BITS'(32);
            material_count_reg <= COUNT_BITS'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:      map_width_reg      <= cfg_data[DIM_BITS-1:0];
                REG_MAP_HEIGHT:     map_height_reg     <= cfg_data[DIM_BITS-1:0];
                REG_TILE_SIZE:      tile_size_reg      <= cfg_data[SIZE_BITS-1:0];
                REG_MATERIAL_COUNT: material_count_reg <= cfg_data;
                default:            map_width_reg      <= map_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clear_en)
        begin
            clr_cnt_reg <= ADDR_BITS'(clr_cnt_reg + 1'b1);
        end
    end

    assign stat.clear_last = &clr_cnt_reg;

    assign wr_addr_full = (ADDR_BITS+1)'(tile_row) * (ADDR_BITS+1)'(w_eff)
                        + (ADDR_BITS+1)'(tile_col);
    assign wr_ok = ({1'b0, tile_col} < w_eff) && ({1'b0, tile_row} < h_eff)
                && ({1'b0, material_in} < material_count_reg);
    assign rd_addr_full = (ADDR_BITS+1)'(y_cnt_reg[COORD_BITS-1:0]) * (ADDR_BITS+1)'(w_eff)
                        + (ADDR_BITS+1)'(x_cnt_reg[COORD_BITS-1:0]);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        if (ctl.clear_en)
        begin
            mem_we = 1'b1;
        end
        else if (ctl.wr_tile && wr_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_full[ADDR_BITS-1:0];
            mem_wdata = material_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr_full[ADDR_BITS-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_view)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            sx_reg <= view_width;
            sy_reg <= view_height;
        end
    end

    always_comb
    begin
        if (ctl.div_sel[1])
        begin
            c2    = SUM_BITS'({cy_reg, 1'b0});
            s_ext = SUM_BITS'({1'b0, sy_reg});
            lim   = h_eff;
        end
        else
        begin
            c2    = SUM_BITS'({cx_reg, 1'b0});
            s_ext = SUM_BITS'({1'b0, sx_reg});
            lim   = w_eff;
        end
        c2 = {{(SUM_BITS-PIX_BITS-1){c2[PIX_BITS]}}, c2[PIX_BITS:0]};
        if (ctl.div_sel[0])
        begin
            sum = c2 + s_ext;
        end
        else
        begin
            sum = c2 - s_ext;
        end
        div_num = sum[SUM_BITS-1] ? '0 : sum[NUM_BITS-1:0];
    end

    tmvs_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctl.div_start),
        .num    (div_num),
        .den    ({t_eff, 1'b0}),
        .done   (div_done),
        .quot   (div_quot),
        .rem_nz (div_rem_nz)
    );

    assign stat.div_done = div_done;

    assign q_adj = {1'b0, div_quot} + (NUM_BITS+1)'(ctl.div_sel[0] & div_rem_nz);
    assign bound = (q_adj > (NUM_BITS+1)'(lim)) ? lim : q_adj[DIM_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.div_capture)
        begin
            case (ctl.div_sel)
                DIV_X_LO: x0_reg <= bound;
                DIV_X_HI: x1_reg <= bound;
                DIV_Y_LO: y0_reg <= bound;
                DIV_Y_HI: y1_reg <= bound;
                default:  x0_reg <= bound;
            endcase
        end
    end

    assign x_cap = DIM_BITS'(x0_reg + DIM_BITS'(VIEW_MAX));
    assign y_cap = DIM_BITS'(y0_reg + DIM_BITS'(VIEW_MAX));
    assign stat.win_empty = (x0_reg >= x1_reg) || (y0_reg >= y1_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.win_load)
        begin
            x_end_reg <= (x1_reg > x_cap) ? x_cap : x1_reg;
            y_end_reg <= (y1_reg > y_cap) ? y_cap : y1_reg;
        end
    end

    assign scan_end = (DIM_BITS'(x_cnt_reg + 1'b1) == x_end_reg)
                   && (DIM_BITS'(y_cnt_reg + 1'b1) == y_end_reg);
    assign stat.scan_end = scan_end;

    always_comb
    begin
        x_cnt_next = x_cnt_reg;
        y_cnt_next = y_cnt_reg;
        if (ctl.win_load)
        begin
            x_cnt_next = x0_reg;
            y_cnt_next = y0_reg;
        end
        else if (ctl.scan_step)
        begin
            if (DIM_BITS'(x_cnt_reg + 1'b1) == x_end_reg)
            begin
                x_cnt_next = x0_reg;
                y_cnt_next = DIM_BITS'(y_cnt_reg + 1'b1);
            end
            else
            begin
                x_cnt_next = DIM_BITS'(x_cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_cnt_reg <= x_cnt_next;
        y_cnt_reg <= y_cnt_next;
    end

    assign px = PROD_BITS'(x_cnt_reg[COORD_BITS-1:0]) * PROD_BITS'(t_eff);
    assign py = PROD_BITS'(y_cnt_reg[COORD_BITS-1:0]) * PROD_BITS'(t_eff);
    assign ox_calc = ORG_BITS'({1'b0, px, 2'b00}) - ORG_BITS'(1);
    assign oy_calc = ORG_BITS'({1'b0, py, 2'b00}) - ORG_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ctl.scan_step || ctl.emit_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scan_step)
        begin
            tv_reg   <= 1'b1;
            col_reg  <= x_cnt_reg[COORD_BITS-1:0];
            row_reg  <= y_cnt_reg[COORD_BITS-1:0];
            ox_reg   <= ox_calc;
            oy_reg   <= oy_calc;
            last_reg <= scan_end;
        end
        else if (ctl.emit_empty)
        begin
            tv_reg   <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
            last_reg <= 1'b1;
        end
    end

    assign out_valid    = ov_reg;
    assign tile_valid   = tv_reg;
    assign out_col      = col_reg;
    assign out_row      = row_reg;
    assign out_material = tv_reg ? rdata_reg : '0;
    assign origin_x_q   = ox_reg;
    assign origin_y_q   = oy_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/tmvs_ctrl.sv =====
`timescale 1ns / 1ps

module tmvs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  cmd,
    output logic                  busy,
    output tmvs_pkg::tmvs_cmd_t   ctl,
    input  tmvs_pkg::tmvs_stat_t  stat
);
    import tmvs_pkg::*;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DIVGO   = 3'd2;
    localparam logic [2:0] S_DIVWAIT = 3'd3;
    localparam logic [2:0] S_WIN     = 3'd4;
    localparam logic [2:0] S_SCAN    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        ctl        = '0;
        ctl.div_sel = sel_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_VIEW)
                    begin
                        ctl.load_view = 1'b1;
                        sel_next      = DIV_X_LO;
                        state_next    = S_DIVGO;
                    end
                    else
                    begin
                        ctl.wr_tile = 1'b1;
                    end
                end
            end
            S_DIVGO:
            begin
                ctl.div_start = 1'b1;
                state_next    = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (stat.div_done)
                begin
                    ctl.div_capture = 1'b1;
                    if (sel_reg == DIV_Y_HI)
                    begin
                        state_next = S_WIN;
                    end
                    else
                    begin
                        sel_next   = 2'(sel_reg + 1'b1);
                        state_next = S_DIVGO;
                    end
                end
            end
            S_WIN:
            begin
                ctl.win_load = 1'b1;
                if (stat.win_empty)
                begin
                    ctl.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            sel_reg   <= DIV_X_LO;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tmvs_pkg::*;

    localparam int SETTLE_CYCLES = 160;

    typedef struct {
        logic                        cmd;
        logic [COORD_BITS-1:0]       col;
        logic [COORD_BITS-1:0]       row;
        logic [MATERIAL_BITS-1:0]    mat;
        logic signed [PIX_BITS-1:0]  cx;
        logic signed [PIX_BITS-1:0]  cy;
        logic [PIX_BITS-1:0]         vw;
        logic [PIX_BITS-1:0]         vh;
    } scan_item_t;

    typedef struct {
        logic                        valid;
        logic [COORD_BITS-1:0]       col;
        logic [COORD_BITS-1:0]       row;
        logic [MATERIAL_BITS-1:0]    mat;
        logic signed [ORG_BITS-1:0]  ox;
        logic signed [ORG_BITS-1:0]  oy;
        logic                        last;
    } tile_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic cmd = 1'b0;
    logic [COORD_BITS-1:0] tile_col = '0;
    logic [COORD_BITS-1:0] tile_row = '0;
    logic [MATERIAL_BITS-1:0] material_in = '0;
    logic signed [PIX_BITS-1:0] center_x = '0;
    logic signed [PIX_BITS-1:0] center_y = '0;
    logic [PIX_BITS-1:0] view_width = '0;
    logic [PIX_BITS-1:0] view_height = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [COUNT_BITS-1:0] cfg_data = '0;
    logic out_valid;
    logic tile_valid;
    logic [COORD_BITS-1:0] out_col;
    logic [COORD_BITS-1:0] out_row;
    logic [MATERIAL_BITS-1:0] out_material;
    logic signed [ORG_BITS-1:0] origin_x_q;
    logic signed [ORG_BITS-1:0] origin_y_q;
    logic last;

    logic [DIM_BITS-1:0]   cfg_map_width = 7'd64;
    logic [DIM_BITS-1:0]   cfg_map_height = 7'd64;
    logic [SIZE_BITS-1:0]  cfg_tile_size = 10'd32;
    logic [COUNT_BITS-1:0] cfg_material_count = 11'd1024;
    logic [MATERIAL_BITS-1:0] tile_mirror [0:STORE_DEPTH-1];

    scan_item_t   pending_items[$];
    tile_result_t expected_tiles[$];
    scan_item_t   cur_item;
    int burst_left = 0;
    int gap_left = 0;
    int error_count = 0;
    int accepted_count = 0;
    int view_count = 0;
    int results_checked = 0;
    int setting_count = 1;

    tile_map_view_scanner u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .tile_col     (tile_col),
        .tile_row     (tile_row),
        .material_in  (material_in),
        .center_x     (center_x),
        .center_y     (center_y),
        .view_width   (view_width),
        .view_height  (view_height),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .tile_valid   (tile_valid),
        .out_col      (out_col),
        .out_row      (out_row),
        .out_material (out_material),
        .origin_x_q   (origin_x_q),
        .origin_y_q   (origin_y_q),
        .last         (last)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            tile_mirror[i] = '0;
        end
    end

    function automatic int unsigned used_cols();
        return (cfg_map_width > MAP_MAX_COLS) ? MAP_MAX_COLS : cfg_map_width;
    endfunction

    function automatic int unsigned used_rows();
        return (cfg_map_height > MAP_MAX_ROWS) ? MAP_MAX_ROWS : cfg_map_height;
    endfunction

    function automatic int unsigned used_tile_size();
        return (cfg_tile_size == 0) ? 1 : cfg_tile_size;
    endfunction

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic void visible_span(input longint c, input longint s, input longint t,
                                         input longint lim, output longint lo,
                                         output longint hi);
        lo = floor_quot(2 * c - s, 2 * t);
        hi = -floor_quot(-(2 * c + s), 2 * t);
        lo = (lo < 0) ? 0 : ((lo > lim) ? lim : lo);
        hi = (hi < 0) ? 0 : ((hi > lim) ? lim : hi);
        if (hi > lo + VIEW_MAX)
        begin
            hi = lo + VIEW_MAX;
        end
    endfunction

    task automatic predict_tiles(input scan_item_t it);
        int unsigned w;
        int unsigned h;
        longint t;
        longint x0;
        longint x1;
        longint y0;
        longint y1;
        longint x;
        longint y;
        tile_result_t r;
        w = used_cols();
        h = used_rows();
        if (it.cmd == CMD_WRITE)
        begin
            if (it.col < w && it.row < h && it.mat < cfg_material_count)
            begin
                tile_mirror[it.col + it.row * w] = it.mat;
            end
        end
        else
        begin
            t = used_tile_size();
            visible_span(it.cx, it.vw, t, w, x0, x1);
            visible_span(it.cy, it.vh, t, h, y0, y1);
            if (x0 >= x1 || y0 >= y1)
            begin
                r = '{valid: 1'b0, col: '0, row: '0, mat: '0, ox: '0, oy: '0, last: 1'b1};
                expected_tiles.push_back(r);
            end
            else
            begin
                for (y = y0; y < y1; y++)
                begin
                    for (x = x0; x < x1; x++)
                    begin
                        r.valid = 1'b1;
                        r.col = x[COORD_BITS-1:0];
                        r.row = y[COORD_BITS-1:0];
                        r.mat = tile_mirror[x + y * w];
                        r.ox = ORG_BITS'(x * t * 4 - 1);
                        r.oy = ORG_BITS'(y * t * 4 - 1);
                        r.last = (y == y1 - 1 && x == x1 - 1);
                        expected_tiles.push_back(r);
                    end
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_tiles(cur_item);
                accepted_count++;
                if (cur_item.cmd == CMD_VIEW)
                begin
                    view_count++;
                end
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    cur_item = pending_items.pop_front();
                    cmd <= cur_item.cmd;
                    tile_col <= cur_item.col;
                    tile_row <= cur_item.row;
                    material_in <= cur_item.mat;
                    center_x <= cur_item.cx;
                    center_y <= cur_item.cy;
                    view_width <= cur_item.vw;
                    view_height <= cur_item.vh;
                    start <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        tile_result_t want;
        if (rst_n && out_valid)
        begin
            if (expected_tiles.size() == 0)
            begin
                $error("Result transfer with no expected tile at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = expected_tiles.pop_front();
                check_field("tile_valid", want.valid, tile_valid);
                check_field("out_col", want.col, out_col);
                check_field("out_row", want.row, out_row);
                check_field("out_material", want.mat, out_material);
                check_field("origin_x_q", want.ox, origin_x_q);
                check_field("origin_y_q", want.oy, origin_y_q);
                check_field("last", want.last, last);
                results_checked++;
            end
        end
    end

    function automatic logic signed [PIX_BITS-1:0] to_pix(input int v);
        if (v > 32767)
        begin
            return 16'sd32767;
        end
        if (v < -32768)
        begin
            return -16'sd32768;
        end
        return v[PIX_BITS-1:0];
    endfunction

    function automatic scan_item_t random_item();
        scan_item_t it;
        int unsigned w;
        int unsigned h;
        int unsigned t;
        int unsigned mat_lim;
        w = used_cols();
        h = used_rows();
        t = used_tile_size();
        mat_lim = (cfg_material_count == 0) ? 1 :
                  ((cfg_material_count > 1024) ? 1024 : cfg_material_count);
        it.col = COORD_BITS'($urandom);
        it.row = COORD_BITS'($urandom);
        it.mat = MATERIAL_BITS'($urandom);
        it.cx = PIX_BITS'($urandom);
        it.cy = PIX_BITS'($urandom);
        it.vw = PIX_BITS'($urandom);
        it.vh = PIX_BITS'($urandom);
        if ($urandom_range(0, 2) == 0)
        begin
            it.cmd = CMD_WRITE;
            if ($urandom_range(0, 5) != 0)
            begin
                it.col = COORD_BITS'($urandom_range(0, (w == 0) ? 0 : w - 1));
                it.row = COORD_BITS'($urandom_range(0, (h == 0) ? 0 : h - 1));
                it.mat = MATERIAL_BITS'($urandom_range(0, mat_lim - 1));
            end
        end
        else
        begin
            it.cmd = CMD_VIEW;
            if ($urandom_range(0, 6) != 0)
            begin
                it.cx = to_pix(int'($urandom_range(0, w * t + 2 * t)) - int'(t));
                it.cy = to_pix(int'($urandom_range(0, h * t + 2 * t)) - int'(t));
                it.vw = PIX_BITS'($urandom_range(0, 10 * t));
                it.vh = PIX_BITS'($urandom_range(0, 10 * t));
            end
        end
        return it;
    endfunction

    task automatic push_write(input int col, input int row, input int mat);
        scan_item_t it;
        it = random_item();
        it.cmd = CMD_WRITE;
        it.col = COORD_BITS'(col);
        it.row = COORD_BITS'(row);
        it.mat = MATERIAL_BITS'(mat);
        pending_items.push_back(it);
    endtask

    task automatic push_view(input int cx, input int cy, input int vw, input int vh);
        scan_item_t it;
        it = random_item();
        it.cmd = CMD_VIEW;
        it.cx = to_pix(cx);
        it.cy = to_pix(cy);
        it.vw = PIX_BITS'(vw);
        it.vh = PIX_BITS'(vh);
        pending_items.push_back(it);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            pending_items.push_back(random_item());
        end
    endtask

    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || start || busy || expected_tiles.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[COUNT_BITS-1:0];
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAP_WIDTH:      cfg_map_width = value[DIM_BITS-1:0];
            REG_MAP_HEIGHT:     cfg_map_height = value[DIM_BITS-1:0];
            REG_TILE_SIZE:      cfg_tile_size = value[SIZE_BITS-1:0];
            REG_MATERIAL_COUNT: cfg_material_count = value[COUNT_BITS-1:0];
            default:            ;
        endcase
    endtask

    task automatic set_config(input int unsigned w, input int unsigned h,
                              input int unsigned t, input int unsigned mc);
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
        write_reg(REG_TILE_SIZE, t);
        write_reg(REG_MATERIAL_COUNT, mc);
        setting_count++;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        push_write(0, 0, 1023);
        push_write(63, 63, 1);
        push_write(63, 0, 512);
        push_write(0, 63, 341);
        push_write(5, 5, 682);
        push_view(16, 16, 32, 32);
        push_view(1024, 1024, 65535, 65535);
        push_view(2047, 2047, 64, 64);
        push_view(64, 64, 0, 0);
        push_view(70, 70, 0, 0);
        push_view(-32768, -32768, 0, 0);
        push_view(32767, 32767, 65535, 65535);
        push_view(-32768, 32767, 65535, 65535);
        push_view(32767, 100, 100, 100);
        push_view(0, 2040, 100, 50);
        push_random(8);
        drain();

        set_config(1, 1, 1, 1);
        push_view(0, 0, 2, 2);
        push_write(1, 0, 0);
        push_write(0, 1, 0);
        push_write(0, 0, 1);
        push_write(0, 0, 0);
        push_view(0, 0, 2, 2);
        push_view(0, 0, 0, 0);
        push_random(10);
        drain();

        set_config(64, 64, 1023, 2047);
        push_random(10);
        drain();

        set_config(20, 12, 0, 1024);
        push_random(14);
        drain();

        set_config(0, 0, 8, 0);
        push_random(8);
        drain();

        set_config(127, 100, 7, 300);
        push_random(12);
        drain();

        set_config(13, 9, 5, 17);
        push_random(12);
        drain();

        set_config(64, 1, 64, 1024);
        push_random(14);
        drain();

        $display("Transfers accepted: %0d (%0d view scans) across %0d register settings.",
                 accepted_count, view_count, setting_count);
        $display("Tile results compared: %0d, errors: %0d.", results_checked, error_count);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Run did not complete in the allowed time.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
